### rtl/ldfs_pkg.sv
// Package for the LED digit frame sequencer.
// Holds the item and result types, register indexes and display command addresses.
// No dependencies.
package ldfs_pkg;

   // Default number of display digits.
   localparam int DIGIT_COUNT_DEFAULT = 8;

   // Width of the number field and of the bit counter of the serial divider.
   localparam int NUM_WIDTH = 32;
   localparam int BIT_CNT_WIDTH = 5;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DIGITS_IN_USE = 2'd0;
   localparam logic [1:0] CSR_DECODE_MASK   = 2'd1;
   localparam logic [1:0] CSR_INTENSITY     = 2'd2;
   localparam logic [1:0] CSR_TEST_ENABLE   = 2'd3;

   // Display controller register addresses.
   localparam logic [7:0] ADDR_DECODE     = 8'h09;
   localparam logic [7:0] ADDR_INTENSITY  = 8'h0A;
   localparam logic [7:0] ADDR_SCAN_LIMIT = 8'h0B;
   localparam logic [7:0] ADDR_SHUTDOWN   = 8'h0C;
   localparam logic [7:0] ADDR_TEST       = 8'h0F;
   localparam logic [7:0] BLANK_CODE      = 8'h0F;

   // Operation codes.
   localparam logic OP_INIT = 1'b0;
   localparam logic OP_SHOW = 1'b1;

   // One input item.
   typedef struct packed {
      logic                        operation;
      logic signed [NUM_WIDTH-1:0] number;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [15:0] frame;
      logic        last;
   } rsp_type;

endpackage

### rtl/led_digit_frame_sequencer.sv
// A show item blanks every digit and then works out each decimal digit with the bit-serial
// divide by ten (one dividend bit a cycle). Busy is high while an item is being processed.
// Reset is synchronous and restores the configuration defaults; results cannot be stalled.
// Depends on ldfs_pkg.
module led_digit_frame_sequencer
   import ldfs_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_payload,
   output logic       rsp_strobe,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int PosW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_BLANK,
      ST_ZERO,
      ST_DIVIDE,
      ST_DIGIT,
      ST_FLUSH
   } state_type;

   state_type              state_ff;
   logic [3:0]             digits_ff;
   logic [7:0]             mask_ff;
   logic [3:0]             intensity_ff;
   logic                   test_ff;
   logic [2:0]             step_ff;
   logic [PosW-1:0]        pos_ff;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff;
   logic [NUM_WIDTH-1:0]   quot_ff;
   logic [3:0]             rem_ff;
   logic                   neg_ff;
   logic                   pend_valid_ff;
   logic [15:0]            pend_ff;
   logic                   rsp_strobe_ff;
   rsp_type                rsp_ff;

   logic                   produce_in;
   logic [15:0]            frame_in;
   logic [3:0]             digits_sat;
   logic [7:0]             init_data;
   logic [7:0]             init_addr;
   logic [4:0]             trial;
   logic                   sub_ok;
   logic [3:0]             rem_in;
   logic [7:0]             pos_addr;

   assign busy        = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // Scan limit is saturated to the supported digit range.
   always_comb begin
      if (digits_ff == 4'd0) begin
         digits_sat = 4'd1;
      end else if (digits_ff > 4'(DIGIT_COUNT)) begin
         digits_sat = 4'(DIGIT_COUNT);
      end else begin
         digits_sat = digits_ff;
      end
   end

   // Init command words, one per step.
   always_comb begin
      case (step_ff)
         3'd0: begin
            init_addr = ADDR_SHUTDOWN;
            init_data = 8'h00;
         end
         3'd1: begin
            init_addr = ADDR_SCAN_LIMIT;
            init_data = {4'd0, digits_sat - 4'd1};
         end
         3'd2: begin
            init_addr = ADDR_DECODE;
            init_data = mask_ff;
         end
         3'd3: begin
            init_addr = ADDR_INTENSITY;
            init_data = {4'd0, intensity_ff};
         end
         3'd4: begin
            init_addr = ADDR_SHUTDOWN;
            init_data = 8'h01;
         end
         default: begin
            init_addr = ADDR_TEST;
            init_data = {7'd0, test_ff};
         end
      endcase
   end

   // One restoring step of the divide by ten.
   always_comb begin
      trial  = {rem_ff, quot_ff[NUM_WIDTH-1]};
      sub_ok = (trial >= 5'd10);
      rem_in = sub_ok ? 4'(trial - 5'd10) : trial[3:0];
   end

   assign pos_addr = 8'(pos_ff) + 8'd1;

   // Frame produced this cycle, if any.
   always_comb begin
      produce_in = 1'b0;
      frame_in   = 16'h0000;
      case (state_ff)
         ST_INIT: begin
            produce_in = 1'b1;
            frame_in   = {init_addr, init_data};
         end
         ST_BLANK: begin
            produce_in = 1'b1;
            frame_in   = {pos_addr, BLANK_CODE};
         end
         ST_ZERO: begin
            produce_in = 1'b1;
            frame_in   = 16'h0100;
         end
         ST_DIGIT: begin
            produce_in = !neg_ff || (rem_ff == 4'd0);
            frame_in   = {pos_addr, 4'd0, rem_ff};
         end
         default: begin
            produce_in = 1'b0;
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff    <= 4'd8;
         mask_ff      <= 8'hFF;
         intensity_ff <= 4'd1;
         test_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DIGITS_IN_USE: digits_ff    <= csr_data[3:0];
            CSR_DECODE_MASK:   mask_ff      <= csr_data;
            CSR_INTENSITY:     intensity_ff <= csr_data[3:0];
            CSR_TEST_ENABLE:   test_ff      <= csr_data[0];
            default:           test_ff      <= test_ff;
         endcase
      end
   end

   // Sequencer, serial divider and output staging. A frame is held back one step so
   // that the final frame of an item can be marked.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         step_ff       <= 3'd0;
         pos_ff        <= '0;
         bit_cnt_ff    <= '0;
      end else begin
         // A held frame is shown when a newer one displaces it, or at the flush.
         rsp_strobe_ff <= (produce_in && pend_valid_ff) || (state_ff == ST_FLUSH);

         // Release the held frame when a newer one arrives.
         if (produce_in) begin
            if (pend_valid_ff) begin
               rsp_ff.frame  <= pend_ff;
               rsp_ff.last   <= 1'b0;
            end
            pend_ff       <= frame_in;
            pend_valid_ff <= 1'b1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  step_ff    <= 3'd0;
                  pos_ff     <= '0;
                  rem_ff     <= 4'd0;
                  bit_cnt_ff <= '0;
                  neg_ff     <= req_payload.number[NUM_WIDTH-1];
                  quot_ff    <= req_payload.number[NUM_WIDTH-1]
                                ? (NUM_WIDTH'(0) - NUM_WIDTH'(req_payload.number))
                                : NUM_WIDTH'(req_payload.number);
                  state_ff   <= (req_payload.operation == OP_SHOW) ? ST_BLANK : ST_INIT;
               end
            end
            ST_INIT: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd5) begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_BLANK: begin
               if (pos_ff == PosW'(DIGIT_COUNT - 1)) begin
                  pos_ff   <= '0;
                  state_ff <= (quot_ff == '0) ? ST_ZERO : ST_DIVIDE;
               end else begin
                  pos_ff <= pos_ff + PosW'(1);
               end
            end
            ST_ZERO: begin
               state_ff <= ST_FLUSH;
            end
            ST_DIVIDE: begin
               rem_ff     <= rem_in;
               quot_ff    <= {quot_ff[NUM_WIDTH-2:0], sub_ok};
               bit_cnt_ff <= bit_cnt_ff + BIT_CNT_WIDTH'(1);
               if (bit_cnt_ff == BIT_CNT_WIDTH'(NUM_WIDTH - 1)) begin
                  state_ff <= ST_DIGIT;
               end
            end
            ST_DIGIT: begin
               // Digits past the last display position are dropped.
               if ((quot_ff == '0) || (pos_ff == PosW'(DIGIT_COUNT - 1))) begin
                  state_ff <= ST_FLUSH;
               end else begin
                  pos_ff     <= pos_ff + PosW'(1);
                  rem_ff     <= 4'd0;
                  bit_cnt_ff <= '0;
                  state_ff   <= ST_DIVIDE;
               end
            end
            ST_FLUSH: begin
               rsp_ff.frame  <= pend_ff;
               rsp_ff.last   <= 1'b1;
               pend_valid_ff <= 1'b0;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/ldfs_checker.sv
// Port-level checks for the LED digit frame sequencer, bound to the top level.
// Depends on ldfs_pkg and led_digit_frame_sequencer.
module ldfs_checker
   import ldfs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   // An accepted item keeps the block busy.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an item was accepted");

   // A frame that is not the last one is shown only while the item is still running.
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |-> busy)
      else $error("non-final frame shown while idle");

   // The block goes idle exactly as the final frame is shown.
   a_fall_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_strobe && rsp_payload.last)
      else $error("busy fell without a final frame");

   // No frame follows the final one directly.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.last |=> !rsp_strobe)
      else $error("frame shown directly after the final frame");

endmodule

bind led_digit_frame_sequencer ldfs_checker u_ldfs_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);

### tb/ldfs_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker for the LED digit frame sequencer: predicts the command frames of each item
// and compares them with the frames the block emits, in order.
// Depends on ldfs_pkg.
module ldfs_frame_checker
   import ldfs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_payload,
   input  logic       rsp_strobe,
   input  rsp_type    rsp_payload,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output int         fail_count,
   output int         pending_count
);

   localparam int DIGITS = DIGIT_COUNT_DEFAULT;

   // Shadow copy of the configuration registers.
   logic [3:0] digits_copy;
   logic [7:0] decode_copy;
   logic [3:0] intensity_copy;
   logic       test_copy;

   // Frames predicted but not yet seen, oldest first.
   rsp_type frames_due[$];
   rsp_type oldest;
   int      failures = 0;

   assign fail_count = failures;

   // Work out every frame an item causes and queue them, marking the final one.
   task automatic predict_frames(input req_type item);
      logic [15:0] run [16];
      rsp_type     entry;
      int          count;
      int          position;
      logic [31:0] magnitude;
      logic [3:0]  digit;
      logic [3:0]  scan;
      logic        negative;
      count = 0;
      if (item.operation == OP_INIT) begin
         // The scan limit is saturated to the valid digit range before one is taken off.
         scan = digits_copy;
         if (scan < 4'd1) scan = 4'd1;
         if (scan > DIGITS) scan = 4'(DIGITS);
         run[0] = {ADDR_SHUTDOWN, 8'h00};
         run[1] = {ADDR_SCAN_LIMIT, 4'h0, scan - 4'd1};
         run[2] = {ADDR_DECODE, decode_copy};
         run[3] = {ADDR_INTENSITY, 4'h0, intensity_copy};
         run[4] = {ADDR_SHUTDOWN, 8'h01};
         run[5] = {ADDR_TEST, 7'h00, test_copy};
         count = 6;
      end else begin
         negative = item.number[NUM_WIDTH-1];
         magnitude = item.number;
         if (negative) magnitude = 32'd0 - magnitude;
         // Blank every digit first.
         for (int a = 1; a <= DIGITS; a++) begin
            run[count] = {8'(a), BLANK_CODE};
            count++;
         end
         if (magnitude == 32'd0) begin
            run[count] = {8'd1, 8'd0};
            count++;
         end
         // Least significant digit first; a negative number only keeps its zero digits,
         // and digits past the last display position are dropped.
         position = 0;
         while (magnitude != 32'd0) begin
            digit = 4'(magnitude % 32'd10);
            magnitude = magnitude / 32'd10;
            if (position < DIGITS && (!negative || digit == 4'd0)) begin
               run[count] = {8'(position + 1), 4'h0, digit};
               count++;
            end
            position++;
         end
      end
      for (int i = 0; i < count; i++) begin
         entry.frame = run[i];
         entry.last = (i == count - 1);
         frames_due.push_back(entry);
      end
   endtask

   // Follow register writes, predict accepted items and check each emitted frame.
   always @(posedge clock) begin
      if (reset) begin
         digits_copy <= 4'd8;
         decode_copy <= 8'hFF;
         intensity_copy <= 4'd1;
         test_copy <= 1'b0;
         frames_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DIGITS_IN_USE: digits_copy <= csr_data[3:0];
               CSR_DECODE_MASK:   decode_copy <= csr_data;
               CSR_INTENSITY:     intensity_copy <= csr_data[3:0];
               CSR_TEST_ENABLE:   test_copy <= csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) predict_frames(req_payload);
         if (rsp_strobe) begin
            if (frames_due.size() == 0) begin
               $error("frame: expected none, actual %h", rsp_payload.frame);
               failures++;
            end else begin
               oldest = frames_due.pop_front();
               if (rsp_payload.frame !== oldest.frame) begin
                  $error("frame: expected %h, actual %h", oldest.frame, rsp_payload.frame);
                  failures++;
               end
               if (rsp_payload.last !== oldest.last) begin
                  $error("last: expected %b, actual %b", oldest.last, rsp_payload.last);
                  failures++;
               end
            end
         end
      end
      pending_count <= frames_due.size();
   end

endmodule

### tb/led_digit_frame_sequencer_test.sv
`timescale 1ns / 100ps
// Top of the LED digit frame sequencer testbench: clock, reset, register writes and items.
// Depends on ldfs_pkg, led_digit_frame_sequencer and ldfs_frame_checker.
module led_digit_frame_sequencer_test;
   import ldfs_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_payload;
   logic       rsp_strobe;
   rsp_type    rsp_payload;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_data;
   int         fail_count;
   int         pending_count;
   int         cycle_count = 0;

   led_digit_frame_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   ldfs_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_payload   (req_payload),
      .rsp_strobe    (rsp_strobe),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("led_digit_frame_sequencer_test NOT OK");
         $finish;
      end
   end

   // Offer one item and hold it until the block takes it; start is left high.
   task automatic send_item(input logic operation, input logic [31:0] number);
      req_type item;
      item.operation = operation;
      item.number = number;
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
   endtask

   // Let the sender idle for a random stretch after an item.
   task automatic sender_gap(input int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Wait until every predicted frame has come and the block has gone quiet.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   // One register write; valid is left high for a following write.
   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [7:0] digits, input logic [7:0] mask,
                            input logic [7:0] level, input logic [7:0] test);
      write_reg(CSR_DIGITS_IN_USE, digits);
      write_reg(CSR_DECODE_MASK, mask);
      write_reg(CSR_INTENSITY, level);
      write_reg(CSR_TEST_ENABLE, test);
      csr_valid <= 1'b0;
   endtask

   // Random items: mostly numbers built digit by digit with plenty of zeros,
   // some raw 32-bit values and zeros, and a share of init items.
   task automatic random_phase(input int item_total, input int idle_pct);
      longint value;
      int     length;
      int     pick;
      for (int n = 0; n < item_total; n++) begin
         if (n % 30 == 0) begin
            drain();
            configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
         end
         pick = $urandom_range(99);
         if (pick < 20) begin
            send_item(OP_INIT, $urandom);
         end else if (pick < 32) begin
            send_item(OP_SHOW, $urandom);
         end else if (pick < 37) begin
            send_item(OP_SHOW, 32'd0);
         end else begin
            length = $urandom_range(1, 10);
            value = $urandom_range(1, 9);
            for (int i = 1; i < length; i++)
               value = value * 10 + (($urandom_range(99) < 35) ? 0 : $urandom_range(1, 9));
            if (value > 64'd2147483647) value = value % 64'd2147483648;
            if ($urandom_range(1) == 1) value = -value;
            send_item(OP_SHOW, value[31:0]);
         end
         sender_gap(idle_pct);
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_DIGITS_IN_USE;
      csr_data <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items on the reset configuration: zero, both signs, the 32-bit extremes,
      // numbers longer than the display and negatives with zero digits.
      send_item(OP_INIT, 32'hFFFFFFFF);
      send_item(OP_SHOW, 32'd0);
      send_item(OP_SHOW, 32'd1);
      send_item(OP_SHOW, 32'hFFFFFFFF);
      send_item(OP_SHOW, 32'h7FFFFFFF);
      send_item(OP_SHOW, 32'h80000000);
      send_item(OP_SHOW, 32'h80000001);
      send_item(OP_SHOW, 32'd12345678);
      send_item(OP_SHOW, 32'd123456789);
      send_item(OP_SHOW, 32'd1000000000);
      send_item(OP_SHOW, -32'sd1000000000);
      send_item(OP_SHOW, -32'sd100);
      send_item(OP_SHOW, -32'sd10);
      send_item(OP_SHOW, 32'd99999999);
      send_item(OP_SHOW, 32'd100000000);

      // Register extremes, including digit counts that saturate at both ends
      // and upper data bits that the registers drop.
      drain();
      configure(8'h00, 8'h00, 8'h0F, 8'h01);
      send_item(OP_INIT, 32'd0);
      drain();
      configure(8'hFF, 8'hAA, 8'hF0, 8'hFE);
      send_item(OP_INIT, 32'h55555555);
      drain();
      configure(8'h09, 8'h55, 8'h07, 8'h01);
      send_item(OP_INIT, 32'd0);
      drain();
      configure(8'h01, 8'hFF, 8'h00, 8'h00);
      send_item(OP_INIT, 32'd0);
      send_item(OP_SHOW, 32'd42);
      drain();
      configure(8'h08, 8'h0F, 8'h01, 8'h00);
      send_item(OP_INIT, 32'd0);

      // Random part: sender idles seldom, then often, then never.
      random_phase(63, 22);
      random_phase(63, 72);
      random_phase(63, 0);
      drain();

      if (fail_count == 0)
         $display("led_digit_frame_sequencer_test OK");
      else
         $display("led_digit_frame_sequencer_test NOT OK");
      $finish;
   end

endmodule
